/* rtl/acws_pkg.sv */
// shared constants and types for the word segmentation block
`timescale 1ns / 1ps
package acws_pkg;
	localparam int MAX_NODES_D = 256;
	localparam int ALPHABET_D  = 26;
	localparam int WINDOW_D    = 32;
	localparam int MAX_TEXT_D  = 1048575;
	localparam int LEN_W       = 20;

	localparam logic [1:0] KIND_DICT  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_TEXT  = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_CLEAR = 4'd1,
		OP_DICT  = 4'd2,
		OP_BINIT = 4'd3,
		OP_BPOP  = 4'd4,
		OP_BNODE = 4'd5,
		OP_BCHLD = 4'd6,
		OP_BFIN  = 4'd7,
		OP_TEXT  = 4'd8
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] phase;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic queue_empty;
		logic step_done;
	} status_t;
endpackage

/* rtl/acws_if.sv */
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface acws_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [4:0] letter;
	logic       last;
	modport source (output valid, kind, letter, last, input ready);
	modport sink (input valid, kind, letter, last, output ready);
endinterface

interface acws_out_if;
	logic        valid;
	logic        ready;
	logic [19:0] prefix_length;
	logic        overflow;
	modport source (output valid, prefix_length, overflow, input ready);
	modport sink (input valid, prefix_length, overflow, output ready);
endinterface

/* rtl/acws_ctrl.sv */
// controller: sequences clearing, dictionary, build and text steps
`timescale 1ns / 1ps
module acws_ctrl
	import acws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_kind,
	input  logic       built,
	input  logic       out_busy,
	input  status_t    st,
	output cmd_t       cmd,
	output logic       latch
);
	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_DICT  = 8'b00000100,
		S_BINIT = 8'b00001000,
		S_BPOP  = 8'b00010000,
		S_BNODE = 8'b00100000,
		S_BCHLD = 8'b01000000,
		S_TEXT  = 8'b10000000
	} state_t;

	state_t     state_q, state_n;
	logic [1:0] phase_q, phase_n;

	assign in_ready = (state_q == S_IDLE) && !out_busy;
	assign latch    = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		phase_n = phase_q + 2'd1;
		cmd.op  = OP_NONE;
		cmd.phase = phase_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clear_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				phase_n = 2'd0;
				if (latch) begin
					unique case (in_kind)
						KIND_DICT:  if (!built) state_n = S_DICT;
						KIND_BUILD: if (!built) state_n = S_BINIT;
						KIND_TEXT:  state_n = S_TEXT;
						default:    state_n = S_IDLE;
					endcase
				end
			end
			S_DICT: begin
				cmd.op = OP_DICT;
				if (st.step_done) state_n = S_IDLE;
			end
			S_BINIT: begin
				cmd.op = OP_BINIT;
				if (st.scan_done) begin
					state_n = S_BPOP;
					phase_n = 2'd0;
				end
			end
			S_BPOP: begin
				if (st.queue_empty) begin
					cmd.op  = OP_BFIN;
					state_n = S_IDLE;
				end else begin
					cmd.op = OP_BPOP;
					if (st.step_done) begin
						state_n = S_BNODE;
						phase_n = 2'd0;
					end
				end
			end
			S_BNODE: begin
				cmd.op = OP_BNODE;
				if (st.step_done) begin
					state_n = S_BCHLD;
					phase_n = 2'd0;
				end
			end
			S_BCHLD: begin
				cmd.op = OP_BCHLD;
				if (st.scan_done) begin
					state_n = S_BPOP;
					phase_n = 2'd0;
				end
			end
			S_TEXT: begin
				cmd.op = OP_TEXT;
				if (st.step_done) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= 2'd0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
		end
	end
endmodule

/* rtl/acws_dp.sv */
// datapath: node stores, breadth-first queue and text window logic
`timescale 1ns / 1ps
module acws_dp
	import acws_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_D,
	parameter int ALPHABET  = ALPHABET_D,
	parameter int WINDOW    = WINDOW_D,
	parameter int MAX_TEXT  = MAX_TEXT_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic             latch,
	input  logic [4:0]       in_letter,
	input  logic             in_last,
	output status_t          st,
	output logic             built,
	output logic             res_valid,
	output logic [LEN_W-1:0] res_len,
	output logic             res_ovf
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int DW = $clog2(WINDOW + 1);
	localparam int AW = NW + CW;
	localparam int TD = MAX_NODES * (1 << CW);
	localparam int QW = NW + 1;

	// transition store, addressed {node, letter}
	logic [NW-1:0]     tt_mem [TD];
	logic [NW-1:0]     tt_rd;
	logic [AW-1:0]     tt_ra, tt_wa;
	logic [NW-1:0]     tt_wd;
	logic              tt_we;
	// per-node store: end mark, depth, failure link, mask
	logic              we_mem [MAX_NODES];
	logic [DW-1:0]     dp_mem [MAX_NODES];
	logic [NW-1:0]     fl_mem [MAX_NODES];
	logic [WINDOW-1:0] lm_mem [MAX_NODES];
	logic [NW-1:0]     q_mem  [MAX_NODES];

	logic [AW-1:0]     clr_q;
	logic [NW-1:0]     cnt_q, cur_q, mnode_q, u_q, f_q;
	logic              drop_q, built_q, ovf_q;
	logic [QW-1:0]     head_q, tail_q;
	logic [CW-1:0]     c_q;
	logic [4:0]        let_q;
	logic              last_q;
	logic [WINDOW-1:0] win_q;
	logic [LEN_W-1:0]  best_q, pos_q;
	logic [DW-1:0]     ud_q;
	logic              uwe_q;
	logic [NW-1:0]     vf_q;

	// node side read ports (registered)
	logic [NW-1:0]     na;
	logic              we_rd;
	logic [DW-1:0]     dp_rd;
	logic [NW-1:0]     fl_rd;
	logic [WINDOW-1:0] lm_rd;
	logic [NW-1:0]     q_rd;
	logic              nd_we, fl_we, lm_we, we_we, q_we;
	logic [NW-1:0]     nd_wa, fl_wa, lm_wa, we_wa;
	logic [DW-1:0]     nd_wd;
	logic [NW-1:0]     fl_wd;
	logic [WINDOW-1:0] lm_wd;

	logic [CW:0] alpha_last;
	assign alpha_last = (CW + 1)'(ALPHABET - 1);

	function automatic logic [AW-1:0] ta(input logic [NW-1:0] n, input logic [CW-1:0] c);
		ta = {n, c};
	endfunction

	logic in_alpha;
	assign in_alpha = ({{(CW + 1 > 5 ? CW - 4 : 1){1'b0}}, let_q} < (ALPHABET));

	logic [CW-1:0] let_c;
	assign let_c = let_q[CW-1:0] & {CW{1'b1}};

	logic [WINDOW-1:0] win_sh;
	assign win_sh = {win_q[WINDOW-2:0], 1'b0};

	always_comb begin
		tt_ra = '0; tt_we = 1'b0; tt_wa = '0; tt_wd = '0;
		na = '0;
		nd_we = 1'b0; fl_we = 1'b0; lm_we = 1'b0; we_we = 1'b0; q_we = 1'b0;
		nd_wa = '0; fl_wa = '0; lm_wa = '0; we_wa = '0;
		nd_wd = '0; fl_wd = '0; lm_wd = '0;
		st = '0;
		st.queue_empty = (head_q == tail_q);
		case (cmd.op)
			OP_CLEAR: begin
				tt_we = 1'b1; tt_wa = clr_q; tt_wd = '0;
				nd_we = 1'b1; fl_we = 1'b1; lm_we = 1'b1; we_we = 1'b1;
				nd_wa = clr_q[NW-1:0]; fl_wa = clr_q[NW-1:0];
				lm_wa = clr_q[NW-1:0]; we_wa = clr_q[NW-1:0];
				st.clear_done = (clr_q == AW'(TD - 1));
			end
			OP_DICT: begin
				tt_ra = ta(cur_q, let_c);
				st.step_done = (cmd.phase == 2'd1);
				if (cmd.phase == 2'd1) begin
					if (!drop_q && in_alpha && tt_rd == '0 &&
					    ({1'b0, cnt_q} + 1'b1) < (NW + 1)'(MAX_NODES)) begin
						tt_we = 1'b1; tt_wa = ta(cur_q, let_c); tt_wd = cnt_q + 1'b1;
					end
				end
			end
			OP_BINIT: begin
				// read one letter ahead so each cycle acts on its own root child
				tt_ra = ta('0, (cmd.phase == 2'd0) ? c_q : c_q + 1'b1);
				st.scan_done = (cmd.phase != 2'd0) && ({1'b0, c_q} == alpha_last);
				if (cmd.phase != 2'd0 && tt_rd != '0) begin
					fl_we = 1'b1; fl_wa = tt_rd; fl_wd = '0;
					nd_we = 1'b1; nd_wa = tt_rd; nd_wd = DW'(1);
					q_we = 1'b1;
				end
			end
			OP_BPOP: begin
				na = q_rd;
				st.step_done = (cmd.phase == 2'd1);
			end
			OP_BNODE: begin
				// phase0: read u attrs; phase1: read f mask; phase2: write mask
				na = (cmd.phase == 2'd0) ? u_q : ((cmd.phase == 2'd1) ? fl_rd : f_q);
				if (cmd.phase == 2'd2) begin
					lm_we = 1'b1; lm_wa = u_q;
					lm_wd = lm_rd;
					if (uwe_q && ud_q < DW'(WINDOW)) lm_wd = lm_rd | (WINDOW'(1) << ud_q);
				end
				st.step_done = (cmd.phase == 2'd2);
			end
			OP_BCHLD: begin
				// phase0: read t[u][c]; phase1: read t[f][c]; phase2: act
				tt_ra = (cmd.phase == 2'd0) ? ta(u_q, c_q) : ta(f_q, c_q);
				if (cmd.phase == 2'd2) begin
					if (vf_q != '0) begin
						fl_we = 1'b1; fl_wa = vf_q; fl_wd = tt_rd;
						nd_we = 1'b1; nd_wa = vf_q;
						nd_wd = (ud_q < DW'(WINDOW)) ? ud_q + 1'b1 : DW'(WINDOW);
						q_we = (tail_q < QW'(MAX_NODES));
					end else begin
						tt_we = 1'b1; tt_wa = ta(u_q, c_q); tt_wd = tt_rd;
					end
				end
				st.scan_done = (cmd.phase == 2'd2) && ({1'b0, c_q} == alpha_last);
			end
			OP_TEXT: begin
				tt_ra = ta(mnode_q, let_c);
				na = in_alpha ? tt_rd : '0;
				st.step_done = (cmd.phase == 2'd2);
			end
			default: ;
		endcase
		if (cmd.op == OP_DICT && cmd.phase == 2'd1 && last_q && !drop_q) begin
			we_we = 1'b1;
			we_wa = (!drop_q && in_alpha) ?
			        ((tt_rd != '0) ? tt_rd :
			         ((({1'b0, cnt_q} + 1'b1) < (NW + 1)'(MAX_NODES)) ? cnt_q + 1'b1 : cur_q))
			        : cur_q;
		end
	end

	// suppress end mark write on overflow of final letter
	logic dict_ovf;
	assign dict_ovf = (cmd.op == OP_DICT) && (cmd.phase == 2'd1) && !drop_q && in_alpha &&
	                  tt_rd == '0 && !(({1'b0, cnt_q} + 1'b1) < (NW + 1)'(MAX_NODES));

	always_ff @(posedge clk) begin
		tt_rd <= tt_mem[tt_ra];
		if (tt_we) tt_mem[tt_wa] <= tt_wd;
		we_rd <= we_mem[na];
		dp_rd <= dp_mem[na];
		fl_rd <= fl_mem[na];
		lm_rd <= lm_mem[na];
		q_rd  <= q_mem[head_q[NW-1:0]];
		if (we_we && !dict_ovf) we_mem[we_wa] <= (cmd.op != OP_CLEAR);
		if (nd_we) dp_mem[nd_wa] <= nd_wd;
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		if (lm_we) lm_mem[lm_wa] <= lm_wd;
		if (q_we) q_mem[tail_q[NW-1:0]] <= (cmd.op == OP_BINIT) ? tt_rd : vf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0; cnt_q <= '0; cur_q <= '0; mnode_q <= '0; drop_q <= 1'b0;
			built_q <= 1'b0; ovf_q <= 1'b0; head_q <= '0; tail_q <= '0; c_q <= '0;
			win_q <= WINDOW'(1); best_q <= '0; pos_q <= '0; res_valid <= 1'b0;
			u_q <= '0; f_q <= '0; ud_q <= '0; uwe_q <= 1'b0; vf_q <= '0;
			let_q <= '0; last_q <= 1'b0; res_len <= '0; res_ovf <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (latch) begin
				let_q <= in_letter; last_q <= in_last;
			end
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_DICT: if (cmd.phase == 2'd1) begin
					if (!drop_q && in_alpha) begin
						if (tt_rd != '0) cur_q <= tt_rd;
						else if (({1'b0, cnt_q} + 1'b1) < (NW + 1)'(MAX_NODES)) begin
							cnt_q <= cnt_q + 1'b1; cur_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1; drop_q <= 1'b1;
						end
					end
					if (last_q) begin
						cur_q <= '0; drop_q <= 1'b0;
					end
				end
				OP_BINIT: if (cmd.phase != 2'd0) begin
					if (tt_rd != '0) tail_q <= tail_q + 1'b1;
					c_q <= st.scan_done ? '0 : c_q + 1'b1;
				end
				OP_BPOP: if (cmd.phase == 2'd1) begin
					u_q <= q_rd; head_q <= head_q + 1'b1;
				end
				OP_BNODE: begin
					if (cmd.phase == 2'd1) begin
						f_q <= fl_rd; ud_q <= dp_rd; uwe_q <= we_rd;
					end
				end
				OP_BCHLD: begin
					if (cmd.phase == 2'd1) vf_q <= tt_rd;
					if (cmd.phase == 2'd2) begin
						if (vf_q != '0 && q_we) tail_q <= tail_q + 1'b1;
						c_q <= st.scan_done ? '0 : c_q + 1'b1;
					end
				end
				OP_BFIN: begin
					built_q <= 1'b1; cur_q <= '0; drop_q <= 1'b0;
				end
				OP_TEXT: begin
					if (cmd.phase == 2'd1) begin
						mnode_q <= na;
						win_q <= win_sh;
						if (pos_q < LEN_W'(MAX_TEXT)) pos_q <= pos_q + 1'b1;
					end
					if (cmd.phase == 2'd2) begin
						if ((lm_rd & win_q) != '0) begin
							win_q[0] <= 1'b1; best_q <= pos_q;
						end
						if (last_q) begin
							res_valid <= 1'b1;
							res_len <= ((lm_rd & win_q) != '0) ? pos_q : best_q;
							res_ovf <= ovf_q;
							mnode_q <= '0; win_q <= WINDOW'(1); best_q <= '0; pos_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign built = built_q;
endmodule

/* rtl/aho_corasick_word_segmentation.sv */
// top level: dictionary segmentation over a trie automaton
//  channel | dir | fields
//  in      | in  | kind[1:0] letter[4:0] last
//  out     | out | prefix_length[19:0] overflow
// after reset a clearing pass over the transition and node stores runs before any item is taken
// a dictionary letter reads and then writes the transition store; a text letter reads it, then the node mask
// build visits the nodes in breadth-first order and scans every child letter of each node
// a result waits in the output register; the next item is held off until it is taken
`timescale 1ns / 1ps
module aho_corasick_word_segmentation
	import acws_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_D,
	parameter int ALPHABET  = ALPHABET_D,
	parameter int WINDOW    = WINDOW_D,
	parameter int MAX_TEXT  = MAX_TEXT_D
) (
	input logic        clk,
	input logic        arst_n,
	acws_in_if.sink    in_ch,
	acws_out_if.source out_ch
);
	cmd_t             cmd;
	status_t          st;
	logic             latch, built, res_valid, res_ovf, ov_q, ovf_q;
	logic [LEN_W-1:0] res_len, len_q;

	acws_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_kind(in_ch.kind), .built(built), .out_busy(ov_q || res_valid),
		.st(st), .cmd(cmd), .latch(latch)
	);

	acws_dp #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET), .WINDOW(WINDOW),
		.MAX_TEXT(MAX_TEXT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .latch(latch),
		.in_letter(in_ch.letter), .in_last(in_ch.last), .st(st), .built(built),
		.res_valid(res_valid), .res_len(res_len), .res_ovf(res_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; len_q <= '0; ovf_q <= 1'b0;
		end else begin
			if (res_valid) begin
				ov_q <= 1'b1; len_q <= res_len; ovf_q <= res_ovf;
			end else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.prefix_length = len_q;
	assign out_ch.overflow = ovf_q;
endmodule

/* tb/sv/tb_aho_corasick_word_segmentation.sv */
// testbench for the aho-corasick word segmentation block
`timescale 1ns / 1ps
module tb_aho_corasick_word_segmentation;
	import acws_pkg::*;

	typedef struct {
		logic [1:0] kind;
		logic [4:0] letter;
		logic       last;
		bit         drain;
	} letter_item_t;

	typedef struct {
		logic [19:0] prefix_length;
		logic        overflow;
	} seg_result_t;

	localparam int WATCHDOG_LIMIT = 150000;
	localparam int HOLD_CYCLES    = 400;

	logic clk;
	logic arst_n;

	acws_in_if  in_ch ();
	acws_out_if out_ch ();

	aho_corasick_word_segmentation uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// automaton copy kept by the testbench
	logic [7:0]  goto_node [MAX_NODES_D][ALPHABET_D];
	bit          ends_word [MAX_NODES_D];
	int          node_lvl [MAX_NODES_D];
	logic [7:0]  fail_node [MAX_NODES_D];
	logic [31:0] suffix_lens [MAX_NODES_D];
	int          nodes_used;
	int          cursor;
	bit          word_lost;
	bit          trie_built;
	bit          out_of_nodes;
	int          walk_node;
	logic [31:0] split_window;
	int          best_len;
	int          text_pos;

	letter_item_t pending_q[$];
	seg_result_t  segment_q[$];
	letter_item_t offered;

	int items_taken;
	int results_seen;
	int mismatches;
	int idle_run;
	bit held_once;
	int hold_left;
	int texts_sent;

	task automatic add_dict_letter(input int k, input bit fin);
		int n;
		if (!word_lost && k < ALPHABET_D) begin
			n = goto_node[cursor][k];
			if (n == 0) begin
				if (nodes_used + 1 >= MAX_NODES_D) begin
					out_of_nodes = 1;
					word_lost = 1;
				end else begin
					nodes_used++;
					n = nodes_used;
					goto_node[cursor][k] = n;
				end
			end
			if (!word_lost)
				cursor = n;
		end
		if (fin) begin
			if (!word_lost)
				ends_word[cursor] = 1;
			cursor = 0;
			word_lost = 0;
		end
	endtask

	task automatic build_links();
		int order [MAX_NODES_D];
		int head;
		int tail;
		int u;
		int f;
		int v;
		logic [31:0] m;
		head = 0;
		tail = 0;
		for (int c = 0; c < ALPHABET_D; c++) begin
			v = goto_node[0][c];
			if (v != 0 && tail < MAX_NODES_D) begin
				fail_node[v] = 0;
				node_lvl[v] = 1;
				order[tail++] = v;
			end
		end
		while (head < tail) begin
			u = order[head++];
			f = fail_node[u];
			m = suffix_lens[f];
			if (ends_word[u] && node_lvl[u] < WINDOW_D)
				m |= 32'd1 << node_lvl[u];
			suffix_lens[u] = m;
			for (int c = 0; c < ALPHABET_D; c++) begin
				v = goto_node[u][c];
				if (v != 0) begin
					fail_node[v] = goto_node[f][c];
					node_lvl[v] = (node_lvl[u] < WINDOW_D) ? node_lvl[u] + 1 : WINDOW_D;
					if (tail < MAX_NODES_D)
						order[tail++] = v;
				end else begin
					goto_node[u][c] = goto_node[f][c];
				end
			end
		end
		trie_built = 1;
		cursor = 0;
		word_lost = 0;
	endtask

	task automatic predict_item(input letter_item_t it);
		seg_result_t r;
		if (it.kind == KIND_DICT) begin
			if (!trie_built)
				add_dict_letter(it.letter, it.last);
		end else if (it.kind == KIND_BUILD) begin
			if (!trie_built)
				build_links();
		end else if (it.kind == KIND_TEXT) begin
			walk_node = (it.letter < ALPHABET_D) ? goto_node[walk_node][it.letter] : 0;
			split_window = split_window << 1;
			if (text_pos < MAX_TEXT_D)
				text_pos++;
			if ((suffix_lens[walk_node] & split_window) != 0) begin
				split_window[0] = 1'b1;
				best_len = text_pos;
			end
			if (it.last) begin
				r.prefix_length = best_len[19:0];
				r.overflow = out_of_nodes;
				segment_q.push_back(r);
				walk_node = 0;
				split_window = 32'd1;
				best_len = 0;
				text_pos = 0;
			end
		end
	endtask

	task automatic queue_item(input logic [1:0] kind, input int letter, input bit last,
			input bit drain = 0);
		letter_item_t it;
		it.kind = kind;
		it.letter = letter[4:0];
		it.last = last;
		it.drain = drain;
		pending_q.push_back(it);
	endtask

	task automatic queue_word(input logic [1:0] kind, input int len, input int top,
			input bit drain = 0);
		for (int i = 0; i < len; i++)
			queue_item(kind, $urandom_range(top), i == len - 1, drain && i == 0);
	endtask

	// text letters mostly from the dictionary's small alphabet so words match
	task automatic queue_text(input int len, input bit drain = 0);
		int l;
		for (int i = 0; i < len; i++) begin
			l = ($urandom_range(99) < 88) ? $urandom_range(3) : $urandom_range(31);
			queue_item(KIND_TEXT, l, i == len - 1, drain && i == 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_DICT;
		in_ch.letter = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		repeat (3) begin
			#10 clk = 1'b1;
			#10 clk = 1'b0;
		end
		arst_n = 1'b1;
		forever #10 clk = ~clk;
	end

	initial begin
		for (int n = 0; n < MAX_NODES_D; n++) begin
			for (int c = 0; c < ALPHABET_D; c++)
				goto_node[n][c] = '0;
			ends_word[n] = 0;
			node_lvl[n] = 0;
			fail_node[n] = '0;
			suffix_lens[n] = '0;
		end
		nodes_used = 0;
		cursor = 0;
		word_lost = 0;
		trie_built = 0;
		out_of_nodes = 0;
		walk_node = 0;
		split_window = 32'd1;
		best_len = 0;
		text_pos = 0;

		// text before build on the bare trie, unknown kind
		queue_item(KIND_DICT, 0, 1);
		queue_item(KIND_TEXT, 0, 0);
		queue_item(KIND_TEXT, 31, 1);
		queue_item(2'd3, 5, 1);
		// out of alphabet letters in a dictionary word, and alone at the root
		queue_item(KIND_DICT, 1, 0);
		queue_item(KIND_DICT, 27, 1);
		queue_item(KIND_DICT, 30, 1);
		queue_item(KIND_DICT, 25, 1);
		queue_item(KIND_DICT, 16, 0);
		queue_item(KIND_DICT, 15, 1);
		// longest word that still fits the window, and one that is too long
		for (int i = 0; i < 31; i++)
			queue_item(KIND_DICT, 2, i == 30);
		for (int i = 0; i < 33; i++)
			queue_item(KIND_DICT, 3, i == 32);

		for (int w = 0; w < 55; w++)
			queue_word(KIND_DICT, $urandom_range(5, 1), ($urandom_range(9) == 0) ? 31 : 3);
		queue_text(6);
		// long random words run the node store out
		for (int w = 0; w < 8; w++)
			queue_word(KIND_DICT, $urandom_range(45, 30), 25);
		queue_word(KIND_DICT, 3, 3);
		// unfinished word left in the trie at build
		queue_item(KIND_DICT, 1, 0);
		queue_item(KIND_DICT, 2, 0);
		queue_item(KIND_BUILD, 0, 0, 1);
		queue_item(KIND_DICT, 0, 1);
		queue_item(KIND_BUILD, 0, 1);

		for (int i = 0; i < 31; i++)
			queue_item(KIND_TEXT, 2, i == 30, i == 0);
		for (int i = 0; i < 33; i++)
			queue_item(KIND_TEXT, 3, i == 32);
		queue_item(KIND_TEXT, 0, 1);
		queue_item(KIND_TEXT, 28, 1);

		while (texts_sent < 1050) begin
			case ($urandom_range(19))
				0: begin
					queue_text($urandom_range(45, 30));
					texts_sent += 38;
				end
				1: begin
					queue_item($urandom_range(1) ? KIND_DICT : 2'd3, $urandom_range(31),
						$urandom_range(1));
					texts_sent++;
				end
				2: begin
					queue_text($urandom_range(8, 1), 1);
					texts_sent += 4;
				end
				default: begin
					queue_text($urandom_range(10, 1));
					texts_sent += 5;
				end
			endcase
		end

		wait (arst_n);
		wait (pending_q.size() == 0 && !in_ch.valid);
		wait (segment_q.size() == 0);
		repeat (300) @(posedge clk);
		if (segment_q.size() != 0)
			mismatches++;
		$display("covered %0d items and %0d segmentation results, %0d trie nodes, overflow %0d",
			items_taken, results_seen, nodes_used, out_of_nodes);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("tb_aho_corasick_word_segmentation: PASS");
		else
			$display("tb_aho_corasick_word_segmentation: FAIL");
		$finish;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_DICT;
			in_ch.letter <= '0;
			in_ch.last <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_item(offered);
				items_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				// no random idling between items 700 and 1000
				if (pending_q.size() > 0
						&& !(pending_q[0].drain && segment_q.size() > 0)
						&& !(($urandom_range(99) < 6) && !(items_taken > 700 && items_taken < 1000)))
				begin
					offered = pending_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= offered.kind;
					in_ch.letter <= offered.letter;
					in_ch.last <= offered.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			held_once <= 0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (results_seen == 25 && !held_once) begin
			held_once <= 1;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(($urandom_range(99) < 6) && !(results_seen > 60 && results_seen < 100));
		end
	end

	// result checker
	always @(posedge clk) begin
		seg_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (segment_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: prefix_length %0d overflow %0d",
						out_ch.prefix_length, out_ch.overflow);
			end else begin
				exp_r = segment_q.pop_front();
				if (out_ch.prefix_length !== exp_r.prefix_length
						|| out_ch.overflow !== exp_r.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected len %0d ovf %0d, got len %0d ovf %0d",
							results_seen, exp_r.prefix_length, exp_r.overflow,
							out_ch.prefix_length, out_ch.overflow);
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", segment_q.size());
			$display("tb_aho_corasick_word_segmentation: FAIL");
			$finish;
		end
	end
endmodule
